>>> rtl/grbf_pkg.sv
// Shared types, constants and the table generator for the Gaussian RBF kernel core.
// Used by grbf_ctrl, grbf_datapath and gaussian_rbf_kernel_core; depends on nothing.
package grbf_pkg;

    localparam int unsigned SUM_W          = 48;
    localparam int unsigned ELEM_W         = 16;
    localparam int unsigned SQ_W           = 32;
    localparam int unsigned IW_W           = 32;
    localparam int unsigned KV_W           = 16;
    localparam int unsigned EXP_TABLE_SIZE = 256;

    localparam logic [IW_W-1:0] INV_WIDTH_RST = 32'h0001_0000;
    localparam logic [31:0]     LOG2E_Q31     = 32'hB8AA_3B29;
    localparam logic [63:0]     LN2_Q62       = 64'h2C5C_85FD_F473_DE6A;
    localparam logic [63:0]     ONE_Q62       = 64'h4000_0000_0000_0000;
    localparam logic [52:0]     Q_LIMIT       = 53'd3221225472;

    typedef enum logic [2:0] {
        S_ACC,
        S_DRAIN,
        S_MUL_LO,
        S_MUL_HI,
        S_RANGE,
        S_LOG,
        S_INDEX,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic take_in;
        logic mul_lo;
        logic mul_hi;
        logic range_chk;
        logic log_mul;
        logic index;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // One table entry: round(65535 * 2^(-k/N)) with x = k * step, step = ln2/N in Q62.
    function automatic logic [15:0] exp_entry(input int unsigned k, input logic [63:0] step);
        logic [63:0]  x;
        logic [63:0]  term;
        logic [63:0]  val;
        logic [63:0]  e46;
        logic [127:0] prod;
        logic [63:0]  rnd;
        x    = step * 64'(k);
        term = ONE_Q62;
        val  = ONE_Q62;
        for (int i = 1; i <= 30; i++) begin
            prod = {64'd0, term} * {64'd0, x};
            term = prod[125:62] / 64'(i);
            if (i % 2 == 1)
                val = val - term;
            else
                val = val + term;
        end
        e46 = val >> 16;
        rnd = (64'd65535 * e46 + (64'd1 << 45)) >> 46;
        return rnd[15:0];
    endfunction

endpackage

>>> rtl/grbf_ctrl.sv
// Sequencing state machine for the Gaussian RBF kernel core.
// Depends on grbf_pkg; drives commands into grbf_datapath.
module grbf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    input  grbf_pkg::status_t status,
    output logic              in_ready,
    output grbf_pkg::cmd_t    cmd
);

    grbf_pkg::state_t state_reg;
    grbf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= grbf_pkg::S_ACC;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            grbf_pkg::S_ACC:
            begin
                in_ready    = 1'b1;
                cmd.take_in = in_valid;
                if (in_valid && in_last)
                    state_next = grbf_pkg::S_DRAIN;
            end
            grbf_pkg::S_DRAIN:
                state_next = grbf_pkg::S_MUL_LO;
            grbf_pkg::S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = grbf_pkg::S_MUL_HI;
            end
            grbf_pkg::S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = grbf_pkg::S_RANGE;
            end
            grbf_pkg::S_RANGE:
            begin
                cmd.range_chk = 1'b1;
                state_next    = grbf_pkg::S_LOG;
            end
            grbf_pkg::S_LOG:
            begin
                cmd.log_mul = 1'b1;
                state_next  = grbf_pkg::S_INDEX;
            end
            grbf_pkg::S_INDEX:
            begin
                cmd.index  = 1'b1;
                state_next = grbf_pkg::S_EMIT;
            end
            grbf_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = grbf_pkg::S_ACC;
                end
            end
            default:
                state_next = grbf_pkg::S_ACC;
        endcase
    end

endmodule

>>> rtl/grbf_datapath.sv
// Datapath of the Gaussian RBF kernel core: squared-difference accumulator,
// shared scaling multiplier, base-2 exponential with table lookup, output register.
// Depends on grbf_pkg; commanded by grbf_ctrl.
module grbf_datapath
#(
    parameter int unsigned EXP_TABLE_SIZE = grbf_pkg::EXP_TABLE_SIZE
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  grbf_pkg::cmd_t                      cmd,
    output grbf_pkg::status_t                   status,
    input  logic signed [grbf_pkg::ELEM_W-1:0]  a_elem,
    input  logic signed [grbf_pkg::ELEM_W-1:0]  b_elem,
    input  logic                                last,
    input  logic                                cfg_valid,
    input  logic [grbf_pkg::IW_W-1:0]           cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [grbf_pkg::KV_W-1:0]           kernel_value,
    output logic                                saturated
);

    localparam int unsigned IDX_W = (EXP_TABLE_SIZE > 1) ? $clog2(EXP_TABLE_SIZE) : 1;
    localparam int unsigned NW    = $clog2(EXP_TABLE_SIZE + 1);
    localparam logic [63:0] STEP  = grbf_pkg::LN2_Q62 / 64'(EXP_TABLE_SIZE);

    logic [15:0] exp_rom [EXP_TABLE_SIZE];

    for (genvar k = 0; k < EXP_TABLE_SIZE; k++)
    begin : g_rom
        localparam logic [15:0] ENTRY = grbf_pkg::exp_entry(k, STEP);
        assign exp_rom[k] = ENTRY;
    end

    logic [grbf_pkg::IW_W-1:0]  iw_reg;
    logic [grbf_pkg::SQ_W-1:0]  sq_reg;
    logic                       sq_vld_reg;
    logic                       sq_last_reg;
    logic [grbf_pkg::SUM_W-1:0] sum_reg;
    logic                       ovf_reg;
    logic [grbf_pkg::SUM_W-1:0] snap_sum_reg;
    logic                       snap_ovf_reg;
    logic [63:0]                plo_reg;
    logic [63:0]                phi_reg;
    logic [31:0]                q_reg;
    logic                       zero_q_reg;
    logic [63:0]                y_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [3:0]                 shift_reg;
    logic                       zero_reg;
    logic [grbf_pkg::KV_W-1:0]  kv_reg;
    logic                       sat_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic signed [16:0]         diff;
    logic [16:0]                mag;
    logic [grbf_pkg::SQ_W-1:0]  sq_next;
    logic [grbf_pkg::SUM_W:0]   acc_sum;
    logic [grbf_pkg::SUM_W-1:0] sum_new;
    logic                       ovf_new;
    logic [15:0]                mul_b;
    logic [63:0]                mul_p;
    logic [52:0]                q_full;
    logic                       zero_q_next;
    logic [46+NW:0]             idx_prod;
    logic                       zero_next;
    logic [15:0]                rom_word;

    // Squared difference of one request
    assign diff    = 17'(a_elem) - 17'(b_elem);
    assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
    assign sq_next = 32'(mag[15:0]) * 32'(mag[15:0]);

    // Saturating accumulate
    assign acc_sum = {1'b0, sum_reg} + 49'(sq_reg);
    assign sum_new = acc_sum[grbf_pkg::SUM_W] ? '1 : acc_sum[grbf_pkg::SUM_W-1:0];
    assign ovf_new = ovf_reg | acc_sum[grbf_pkg::SUM_W];

    // Shared sum * inv_width multiplier, one 16-bit half per cycle
    assign mul_b = cmd.mul_hi ? iw_reg[31:16] : iw_reg[15:0];
    assign mul_p = 64'(snap_sum_reg) * 64'(mul_b);

    assign q_full      = {phi_reg[48:0], 4'd0} + 53'(plo_reg[63:12]);
    assign zero_q_next = (phi_reg[63:48] != 16'd0) || (q_full >= grbf_pkg::Q_LIMIT);

    assign idx_prod  = (47+NW)'(y_reg[58:12]) * (47+NW)'(EXP_TABLE_SIZE);
    assign zero_next = zero_q_reg || y_reg[63];

    assign rom_word = exp_rom[idx_reg];

    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iw_reg        <= grbf_pkg::INV_WIDTH_RST;
            sq_vld_reg    <= 1'b0;
            sq_last_reg   <= 1'b0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                iw_reg <= cfg_data;
            sq_vld_reg    <= cmd.take_in;
            sq_last_reg   <= cmd.take_in && last;
            out_valid_reg <= out_valid_next;
            if (sq_vld_reg)
            begin
                if (sq_last_reg)
                begin
                    sum_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    sum_reg <= sum_new;
                    ovf_reg <= ovf_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
            sq_reg <= sq_next;
        if (sq_vld_reg && sq_last_reg)
        begin
            snap_sum_reg <= sum_new;
            snap_ovf_reg <= ovf_new;
        end
        if (cmd.mul_lo)
            plo_reg <= mul_p;
        if (cmd.mul_hi)
            phi_reg <= mul_p;
        if (cmd.range_chk)
        begin
            q_reg      <= q_full[31:0];
            zero_q_reg <= zero_q_next;
        end
        if (cmd.log_mul)
            y_reg <= 64'(q_reg) * 64'(grbf_pkg::LOG2E_Q31);
        if (cmd.index)
        begin
            idx_reg   <= idx_prod[47 +: IDX_W];
            shift_reg <= y_reg[62:59];
            zero_reg  <= zero_next;
        end
        if (cmd.load_out)
        begin
            kv_reg  <= zero_reg ? '0 : (rom_word >> shift_reg);
            sat_reg <= snap_ovf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kernel_value = kv_reg;
    assign saturated    = sat_reg;

endmodule

>>> rtl/gaussian_rbf_kernel_core.sv
// Top level of the Gaussian RBF kernel core: controller plus datapath.
// Depends on grbf_pkg, grbf_ctrl and grbf_datapath.
//
// Usage:
//   Stream element pairs (a_elem, b_elem) of two equal-length Q3.12 vectors on
//   in_valid/in_ready, one request per cycle; mark the final pair with last.
//   Each pair adds (a-b)^2 to a saturating 48-bit sum.
//   After the last pair the block emits one result on out_valid/out_ready:
//   kernel_value = exp(-sum*inv_width) in Q0.16 and saturated, the sticky
//   overflow flag of that vector. Sum and flag then clear for the next vector.
//   Throughput: one pair per cycle within a vector. After a last pair in_ready
//   stays low while the exponential runs through the shared 48x16 multiplier,
//   the log2(e) multiply, the index multiply and the table lookup, and until
//   the result is loaded into the output register.
//   A stalled receiver holds the result in the output register; the next
//   vector streams in meanwhile, and only its exponential waits for the slot.
//   inv_width (Q16.16) is written on cfg_valid/cfg_ready, always ready; write it
//   only while idle, the block itself does not enforce this. Reset clears the sum
//   and flag, empties the output register and sets inv_width to 1.0.
module gaussian_rbf_kernel_core
#(
    parameter int unsigned EXP_TABLE_SIZE = grbf_pkg::EXP_TABLE_SIZE
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [grbf_pkg::ELEM_W-1:0]  a_elem,
    input  logic signed [grbf_pkg::ELEM_W-1:0]  b_elem,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [grbf_pkg::KV_W-1:0]           kernel_value,
    output logic                                saturated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [grbf_pkg::IW_W-1:0]           cfg_data
);

    grbf_pkg::cmd_t    cmd;
    grbf_pkg::status_t status;

    assign cfg_ready = 1'b1;

    grbf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (last),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    grbf_datapath
    #(
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .a_elem       (a_elem),
        .b_elem       (b_elem),
        .last         (last),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kernel_value (kernel_value),
        .saturated    (saturated)
    );

    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input taken right after a last request");

    a_result_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result loaded while pairs were being accepted");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take_in, cmd.mul_lo, cmd.mul_hi, cmd.range_chk,
                  cmd.log_mul, cmd.index, cmd.load_out}))
        else $error("more than one datapath command in a cycle");

endmodule
